[sv/rebq_pkg.sv]
// rebq_pkg: shared types and constants for the rotary encoder and button qualifier
// used by rebq_step and rotary_encoder_button_qualifier; no dependencies
package rebq_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [15:0] DebounceReset = 16'd50;
  localparam logic [15:0] HoldReset     = 16'd1000;
  localparam logic [15:0] FastGapReset  = 16'd100;
  localparam logic [7:0]  FastStepReset = 8'd5;

  typedef enum logic [1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_HOLD      = 2'd1,
    REG_FAST_GAP  = 2'd2,
    REG_FAST_STEP = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] hold_ms;
    logic [15:0] fast_gap_ms;
    logic [7:0]  fast_step;
  } cfg_t;

  typedef struct packed {
    logic        prev_a;
    logic        prev_b;
    logic        prev_pressed;
    logic        push_flag;
    logic [31:0] switch_edge_time;
    logic [31:0] hold_start_time;
    logic [31:0] last_step_time;
    logic [15:0] position_count;
    logic [15:0] clicks_held;
  } state_t;

  typedef struct packed {
    logic [15:0] position;
    logic [15:0] click_count;
    logic        pushed;
    logic        pressed;
    logic        long_pressed;
    logic        any_activity;
  } result_t;

endpackage

[sv/rotary_encoder_button_qualifier.sv]
// rotary_encoder_button_qualifier: top level with config registers, state and output skid
// depends on rebq_pkg and rebq_step
// a result is registered into the output register, or into the skid entry while the output register is stalled
// throughput: one item per cycle while in_stall is low; rebq_step computes the state update combinationally
// a two-entry output buffer keeps input transfers going while one result waits
// reset (rst_n low, synchronous): registers to defaults, encoder levels high, counts cleared
module rotary_encoder_button_qualifier
  import rebq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic [31:0]          in_now_ms,
  input  logic                 in_pin_a,
  input  logic                 in_pin_b,
  input  logic                 in_pin_switch,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_position,
  output logic [15:0]          out_click_count,
  output logic                 out_pushed,
  output logic                 out_pressed,
  output logic                 out_long_pressed,
  output logic                 out_any_activity,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  state_t   state_r;
  state_t   state_nxt;
  state_t   step_state;
  result_t  step_result;
  result_t  out_r;
  result_t  out_nxt;
  result_t  skid_r;
  result_t  skid_nxt;
  logic     out_valid_r;
  logic     out_valid_nxt;
  logic     skid_valid_r;
  logic     skid_valid_nxt;
  logic     in_xfer;
  logic     out_xfer;
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = reg_idx_t'(paddr[3:2]);

  // register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DEBOUNCE:  cfg_nxt.debounce_ms = pwdata[15:0];
        REG_HOLD:      cfg_nxt.hold_ms     = pwdata[15:0];
        REG_FAST_GAP:  cfg_nxt.fast_gap_ms = pwdata[15:0];
        REG_FAST_STEP: cfg_nxt.fast_step   = pwdata[7:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (cfg_idx)
      REG_DEBOUNCE:  prdata = {16'd0, cfg_r.debounce_ms};
      REG_HOLD:      prdata = {16'd0, cfg_r.hold_ms};
      REG_FAST_GAP:  prdata = {16'd0, cfg_r.fast_gap_ms};
      REG_FAST_STEP: prdata = {24'd0, cfg_r.fast_step};
      default:       prdata = '0;
    endcase
  end

  rebq_step u_step (
    .cfg        (cfg_r),
    .state      (state_r),
    .cmd        (in_cmd),
    .now_ms     (in_now_ms),
    .pin_a      (in_pin_a),
    .pin_b      (in_pin_b),
    .pin_switch (in_pin_switch),
    .state_nxt  (step_state),
    .result     (step_result)
  );

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !skid_valid_r;
  assign out_xfer = out_valid_r && !out_stall;

  assign state_nxt = in_xfer ? step_state : state_r;

  // output buffer with skid entry
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_xfer) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (in_xfer) begin
        out_nxt       = step_result;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_xfer) begin
      skid_nxt       = step_result;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms       <= DebounceReset;
      cfg_r.hold_ms           <= HoldReset;
      cfg_r.fast_gap_ms       <= FastGapReset;
      cfg_r.fast_step         <= FastStepReset;
      state_r.prev_a           <= 1'b1;
      state_r.prev_b           <= 1'b1;
      state_r.prev_pressed     <= 1'b0;
      state_r.push_flag        <= 1'b0;
      state_r.switch_edge_time <= '0;
      state_r.hold_start_time  <= '0;
      state_r.last_step_time   <= '0;
      state_r.position_count   <= '0;
      state_r.clicks_held      <= '0;
      out_valid_r              <= 1'b0;
      skid_valid_r             <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_position     = $signed(out_r.position);
  assign out_click_count  = out_r.click_count;
  assign out_pushed       = out_r.pushed;
  assign out_pressed      = out_r.pressed;
  assign out_long_pressed = out_r.long_pressed;
  assign out_any_activity = out_r.any_activity;

endmodule

[sv/rebq_step.sv]
// rebq_step: next state and status for one transfer (quadrature decode, clicks, clear, restart)
// depends on rebq_pkg
module rebq_step
  import rebq_pkg::*;
(
  input  cfg_t        cfg,
  input  state_t      state,
  input  logic [1:0]  cmd,
  input  logic [31:0] now_ms,
  input  logic        pin_a,
  input  logic        pin_b,
  input  logic        pin_switch,
  output state_t      state_nxt,
  output result_t     result
);

  logic        sw;
  logic [31:0] held_old;
  logic        pr_old;
  logic        act_old;
  logic [31:0] step_gap;
  logic [15:0] inc;
  logic [31:0] held_new;
  logic [31:0] hold_new;
  logic        pr_new;
  logic        pu_new;

  assign sw       = ~pin_switch;
  assign held_old = now_ms - state.switch_edge_time;
  assign pr_old   = state.prev_pressed && (held_old > {16'd0, cfg.debounce_ms});
  assign act_old  = (state.position_count != 16'd0) || (state.clicks_held != 16'd0) || pr_old;
  assign step_gap = now_ms - state.last_step_time;
  assign inc      = (step_gap > {16'd0, cfg.fast_gap_ms}) ? 16'd1 : {8'd0, cfg.fast_step};

  always_comb begin
    state_nxt = state;
    unique case (cmd_t'(cmd))
      CMD_SAMPLE: begin
        if (sw != state.prev_pressed) begin
          if (!sw && (held_old > {16'd0, cfg.debounce_ms}) &&
              (held_old < {16'd0, cfg.hold_ms})) begin
            state_nxt.clicks_held = state.clicks_held + 16'd1;
          end
          state_nxt.prev_pressed     = sw;
          state_nxt.push_flag        = sw;
          state_nxt.switch_edge_time = now_ms;
          state_nxt.hold_start_time  = now_ms;
        end
        if ((pin_a != state.prev_a) || (pin_b != state.prev_b)) begin
          if (pin_a != pin_b) begin
            if ((pin_a && !pin_b) == state.prev_a) begin
              state_nxt.position_count = state.position_count + inc;
            end else begin
              state_nxt.position_count = state.position_count - inc;
            end
            state_nxt.last_step_time = now_ms;
          end
          state_nxt.prev_a = pin_a;
          state_nxt.prev_b = pin_b;
        end
      end
      CMD_CLEAR: begin
        if (act_old) begin
          state_nxt.position_count = 16'd0;
          state_nxt.clicks_held    = 16'd0;
          state_nxt.push_flag      = 1'b0;
        end
      end
      CMD_RESTART: begin
        state_nxt.hold_start_time = now_ms;
      end
      default: begin
        state_nxt = state;
      end
    endcase
  end

  assign held_new = now_ms - state_nxt.switch_edge_time;
  assign hold_new = now_ms - state_nxt.hold_start_time;
  assign pr_new   = state_nxt.prev_pressed && (held_new > {16'd0, cfg.debounce_ms});
  assign pu_new   = state_nxt.push_flag && pr_new;

  always_comb begin
    result.position     = state_nxt.position_count;
    result.click_count  = state_nxt.clicks_held;
    result.pushed       = pu_new;
    result.pressed      = pr_new;
    result.long_pressed = state_nxt.prev_pressed && (hold_new > {16'd0, cfg.hold_ms});
    result.any_activity = (state_nxt.position_count != 16'd0) ||
                          (state_nxt.clicks_held != 16'd0) || pu_new || pr_new;
  end

endmodule
